// ===== hw/rtl/mcd_pkg.sv =====
`default_nettype none

package mcd_pkg;

  // Default channel count and the depth of the tick record queue
  localparam int unsigned MCD_CHANNELS    = 6;
  localparam int unsigned MCD_QUEUE_DEPTH = 2;

  // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam int unsigned TICKS_W     = 8;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd50;

  // Register index, taken from the word address bit
  typedef enum logic {
    REG_ACTIVE_LEVELS  = 1'b0,
    REG_DEBOUNCE_TICKS = 1'b1
  } reg_idx_t;

  // Per-channel debouncer state
  typedef enum logic [1:0] {
    ST_RELEASED   = 2'd0,
    ST_CONF_PRESS = 2'd1,
    ST_PRESSED    = 2'd2,
    ST_CONF_REL   = 2'd3
  } dbc_state_t;

  // Width of an index into n entries, at least one bit
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/multi_channel_debounce_fsm.sv =====
`default_nettype none

// Multi-channel debouncer.
// Input queue side: push one item per timer tick with the raw level of every
// channel on pin_levels; it is taken when push is high and full is low.
// Result queue side: while empty is low, channel, edge_dir and last show the
// oldest confirmed edge; pop takes it. Edges of one tick come in ascending
// channel order and the final one carries last.
// Configuration: APB registers active_levels (0x0) and debounce_ticks (0x4);
// the user must write them only while the block is idle; the block does not
// enforce it, and pready is tied high. A tick's results pass through the
// record queue, the drain register and the output register. Throughput: one
// tick a cycle while the two-entry record queue has room, and one result a
// cycle on the output while the receiver pops; the output paces many-edge ticks.
// Reset: every channel released, countdowns zero, active_levels zero,
// debounce_ticks 50, both queues empty.
// Stall: the output register holds its item, records back up in the queue,
// and full rises once both record entries are taken.
module multi_channel_debounce_fsm
  import mcd_pkg::*;
#(
  parameter int unsigned CHANNELS = MCD_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [CHANNELS-1:0]        pin_levels,
  output logic                       empty,
  input  logic                       pop,
  output logic [idx_w(CHANNELS)-1:0] channel,
  output logic                       edge_dir,
  output logic                       last
);

  logic [CHANNELS-1:0]   active_levels;
  logic [TICKS_W-1:0]    debounce_ticks;
  reg_idx_t              reg_idx;
  logic                  cfg_write;
  logic                  accept;
  logic                  rec_push;
  logic [CHANNELS-1:0]   rec_mask;
  logic [CHANNELS-1:0]   rec_dirs;
  logic                  q_valid;
  logic                  q_pop;
  logic [2*CHANNELS-1:0] q_rdata;

  // Register decode
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels  <= '0;
      debounce_ticks <= TICKS_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ACTIVE_LEVELS:  active_levels  <= pwdata[CHANNELS-1:0];
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_LEVELS:  prdata = APB_DATA_W'(active_levels);
      REG_DEBOUNCE_TICKS: prdata = APB_DATA_W'(debounce_ticks);
      default:            prdata = '0;
    endcase
  end

  assign accept = push && !full;

  mcd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .pin_levels    (pin_levels),
    .active_levels (active_levels),
    .debounce_ticks(debounce_ticks),
    .rec_push      (rec_push),
    .rec_mask      (rec_mask),
    .rec_dirs      (rec_dirs)
  );

  mcd_queue #(
    .WIDTH(2 * CHANNELS),
    .DEPTH(MCD_QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (rec_push),
    .wdata({rec_mask, rec_dirs}),
    .full (full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  mcd_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_mask  (q_rdata[2*CHANNELS-1:CHANNELS]),
    .q_dirs  (q_rdata[CHANNELS-1:0]),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .channel (channel),
    .edge_dir(edge_dir),
    .last    (last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mcd_front.sv =====
`default_nettype none

module mcd_front
  import mcd_pkg::*;
#(
  parameter int unsigned CHANNELS = MCD_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [CHANNELS-1:0] pin_levels,
  input  logic [CHANNELS-1:0] active_levels,
  input  logic [TICKS_W-1:0]  debounce_ticks,
  output logic                rec_push,
  output logic [CHANNELS-1:0] rec_mask,
  output logic [CHANNELS-1:0] rec_dirs
);

  dbc_state_t         state      [CHANNELS];
  dbc_state_t         state_next [CHANNELS];
  logic [TICKS_W-1:0] countdown      [CHANNELS];
  logic [TICKS_W-1:0] countdown_next [CHANNELS];
  logic [CHANNELS-1:0] on_lvl;

  // A channel is active when its raw level matches its configured level
  assign on_lvl = ~(pin_levels ^ active_levels);

  // Step every channel's debouncer for this tick
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      state_next[i]     = state[i];
      countdown_next[i] = countdown[i];
      rec_mask[i]       = 1'b0;
      rec_dirs[i]       = 1'b0;
      unique case (state[i])
        ST_RELEASED: begin
          if (on_lvl[i]) begin
            countdown_next[i] = debounce_ticks;
            state_next[i]     = ST_CONF_PRESS;
          end
        end
        ST_CONF_PRESS: begin
          if (!on_lvl[i]) begin
            state_next[i] = ST_RELEASED;
          end else if (countdown[i] != '0) begin
            countdown_next[i] = countdown[i] - 1'b1;
          end else begin
            rec_mask[i]   = 1'b1;
            rec_dirs[i]   = 1'b1;
            state_next[i] = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (!on_lvl[i]) begin
            countdown_next[i] = debounce_ticks;
            state_next[i]     = ST_CONF_REL;
          end
        end
        ST_CONF_REL: begin
          if (on_lvl[i]) begin
            state_next[i] = ST_PRESSED;
          end else if (countdown[i] != '0) begin
            countdown_next[i] = countdown[i] - 1'b1;
          end else begin
            rec_mask[i]   = 1'b1;
            state_next[i] = ST_RELEASED;
          end
        end
        default: begin
          state_next[i] = ST_RELEASED;
        end
      endcase
    end
  end

  // Queue a record only for ticks that confirm at least one edge
  assign rec_push = accept && (rec_mask != '0);

  // Hold channel state between ticks, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state[i]     <= ST_RELEASED;
        countdown[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state[i]     <= state_next[i];
        countdown[i] <= countdown_next[i];
      end
    end
  end

  // A confirmed edge on channel zero only comes out of a finished countdown
  a_edge_from_zero_count: assert property (@(posedge clk) disable iff (rst)
    (rec_mask[0]) |->
      ((state[0] == ST_CONF_PRESS || state[0] == ST_CONF_REL) && countdown[0] == '0))
    else $error("edge confirmed without an expired countdown");

endmodule

`default_nettype wire

// ===== hw/rtl/mcd_queue.sv =====
`default_nettype none

module mcd_queue
  import mcd_pkg::*;
#(
  parameter int unsigned WIDTH = 2 * MCD_CHANNELS,
  parameter int unsigned DEPTH = MCD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PTR_W = idx_w(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = slot[rd_ptr];

  // Store incoming records
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("record queue underflow");

endmodule

`default_nettype wire

// ===== hw/rtl/mcd_back.sv =====
`default_nettype none

module mcd_back
  import mcd_pkg::*;
#(
  parameter int unsigned CHANNELS = MCD_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [CHANNELS-1:0]         q_mask,
  input  logic [CHANNELS-1:0]         q_dirs,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [idx_w(CHANNELS)-1:0]  channel,
  output logic                        edge_dir,
  output logic                        last
);

  localparam int unsigned CH_W = idx_w(CHANNELS);

  logic [CHANNELS-1:0] cur_mask;
  logic [CHANNELS-1:0] cur_dirs;
  logic [CHANNELS-1:0] pick;
  logic [CHANNELS-1:0] rest;
  logic [CH_W-1:0]     pick_idx;
  logic                out_valid;
  logic                advance;
  logic                emit;
  logic                rec_done;

  // Isolate the lowest pending channel and encode it
  assign pick = cur_mask & (~cur_mask + 1'b1);
  assign rest = cur_mask & ~pick;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | CH_W'(i);
      end
    end
  end

  assign advance  = !out_valid || pop;
  assign emit     = advance && (cur_mask != '0);
  assign rec_done = (cur_mask == '0) || (emit && (rest == '0));
  assign q_pop    = q_valid && rec_done;
  assign empty    = !out_valid;

  // Hold the record being drained; load the next one once it is used up
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (q_pop) begin
      cur_mask <= q_mask;
    end else if (emit) begin
      cur_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_dirs <= q_dirs;
    end
  end

  // Output register: one item a cycle, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel  <= pick_idx;
      edge_dir <= |(cur_dirs & pick);
      last     <= (rest == '0);
    end
  end

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    emit |=> !empty)
    else $error("pending edge not presented");

endmodule

`default_nettype wire

// ===== tb/tb_multi_channel_debounce_fsm.sv =====
`timescale 1ns / 100ps

module tb_multi_channel_debounce_fsm;
  import mcd_pkg::*;

  localparam int unsigned CH         = MCD_CHANNELS;
  localparam int unsigned CH_W       = idx_w(MCD_CHANNELS);
  localparam int          SETTLE     = 16;
  localparam int          STALL_MAX  = 3000;
  localparam int          LONG_HOLD  = 300;
  localparam int          RAND_TICKS = 45;
  localparam int          ABORT_HOLD = 4;
  localparam int          SLOW_TICKS = 10;
  localparam int          SLOW_HOLD  = SLOW_TICKS + 2;

  // One confirmed edge as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            edge_dir;
    logic            last;
  } edge_t;

  // Debounce edge board: per-channel debouncer copy plus the edges still owed
  class debounce_edge_board;
    logic [CH-1:0] active_mask;
    logic [7:0]    load_ticks;
    dbc_state_t    chan_st[CH];
    logic [7:0]    remaining[CH];
    edge_t         owed_edges[$];
    int            errors;
    int            ticks_taken;
    int            presses;
    int            releases;

    function new();
      active_mask = '0;
      load_ticks  = TICKS_RESET;
      foreach (chan_st[i]) begin
        chan_st[i]   = ST_RELEASED;
        remaining[i] = '0;
      end
      errors      = 0;
      ticks_taken = 0;
      presses     = 0;
      releases    = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] wdata);
      case (idx)
        REG_ACTIVE_LEVELS:  active_mask = wdata[CH-1:0];
        REG_DEBOUNCE_TICKS: load_ticks  = wdata[7:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(reg_idx_t idx);
      logic [APB_DATA_W-1:0] v;
      v = '0;
      case (idx)
        REG_ACTIVE_LEVELS:  v[CH-1:0] = active_mask;
        REG_DEBOUNCE_TICKS: v[7:0]    = load_ticks;
        default: ;
      endcase
      return v;
    endfunction

    // Advance every channel by one tick and queue the edges it confirms
    function void note_tick(logic [CH-1:0] levels);
      edge_t tick_edges[$];
      edge_t e;
      logic  on;
      ticks_taken++;
      for (int i = 0; i < CH; i++) begin
        on         = (levels[i] == active_mask[i]);
        e.channel  = CH_W'(i);
        e.last     = 1'b0;
        case (chan_st[i])
          ST_RELEASED: begin
            if (on) begin
              remaining[i] = load_ticks;
              chan_st[i]   = ST_CONF_PRESS;
            end
          end
          ST_CONF_PRESS: begin
            if (!on) begin
              chan_st[i] = ST_RELEASED;
            end else if (remaining[i] != 0) begin
              remaining[i]--;
            end else begin
              e.edge_dir = 1'b1;
              tick_edges.push_back(e);
              chan_st[i] = ST_PRESSED;
            end
          end
          ST_PRESSED: begin
            if (!on) begin
              remaining[i] = load_ticks;
              chan_st[i]   = ST_CONF_REL;
            end
          end
          default: begin
            if (on) begin
              chan_st[i] = ST_PRESSED;
            end else if (remaining[i] != 0) begin
              remaining[i]--;
            end else begin
              e.edge_dir = 1'b0;
              tick_edges.push_back(e);
              chan_st[i] = ST_RELEASED;
            end
          end
        endcase
      end
      if (tick_edges.size() > 0) tick_edges[tick_edges.size()-1].last = 1'b1;
      foreach (tick_edges[k]) owed_edges.push_back(tick_edges[k]);
    endfunction

    // Compare one popped edge with the oldest one owed
    function void check_edge(logic [CH_W-1:0] chan, logic dir, logic lst);
      edge_t want;
      if (owed_edges.size() == 0) begin
        flag($sformatf("unexpected edge ch %0d dir %0b last %0b", chan, dir, lst));
        return;
      end
      want = owed_edges.pop_front();
      if (want.channel !== chan || want.edge_dir !== dir || want.last !== lst)
        flag($sformatf("expected ch %0d dir %0b last %0b, got ch %0d dir %0b last %0b",
                       want.channel, want.edge_dir, want.last, chan, dir, lst));
      if (want.edge_dir) presses++;
      else releases++;
    endfunction

    function int owed();
      return owed_edges.size();
    endfunction
  endclass

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push    = 1'b0;
  logic                  full;
  logic [CH-1:0]         pin_levels = '0;
  logic                  empty;
  logic                  pop     = 1'b0;
  logic [CH_W-1:0]       channel;
  logic                  edge_dir;
  logic                  last;

  debounce_edge_board board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  multi_channel_debounce_fsm #(.CHANNELS(CH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .pin_levels (pin_levels),
    .empty      (empty),
    .pop        (pop),
    .channel    (channel),
    .edge_dir   (edge_dir),
    .last       (last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_MAX) begin
      $display("watchdog: no handshake for %0d cycles, %0d edges still owed",
               STALL_MAX, board.owed());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: check each popped edge, stall at random or for a long hold-off
  initial begin
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && empty === 1'b0) board.check_edge(channel, edge_dir, last);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One APB transfer: setup, access, then return to idle
  task automatic apb_xfer(input logic wr, input reg_idx_t idx,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== board.reg_value(idx))
      board.flag($sformatf("register %s reads %0h, expected %0h",
                           idx.name(), rd, board.reg_value(idx)));
  endtask

  // Write a register with junk above its width, then read it back
  task automatic program_reg(input reg_idx_t idx, input logic [7:0] val);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] unused;
    wdata = $urandom();
    if (idx == REG_ACTIVE_LEVELS) wdata[CH-1:0] = val[CH-1:0];
    else wdata[7:0] = val;
    apb_xfer(1'b1, idx, wdata, unused);
    board.write_reg(idx, wdata);
    check_reg(idx);
  endtask

  // Offer one tick, idling first at random; push stays high for the next one
  task automatic send_tick(input logic [CH-1:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    pin_levels <= levels;
    do @(posedge clk); while (full !== 1'b0);
    board.note_tick(levels);
  endtask

  // Stop offering ticks and wait for every owed edge
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (board.owed() != 0);
  endtask

  // Drain, then let ticks with no edges finish before touching registers
  task automatic quiesce();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly steady levels with random changes, plus glitches and noise
  task automatic run_random(input int n, input int flip_pct, input bit pause_mid);
    logic [CH-1:0] cur;
    logic [CH-1:0] lv;
    int            r;
    cur = CH'($urandom_range(63));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        lv = CH'($urandom_range(63));
      end else if (r < 20) begin
        lv = cur ^ CH'($urandom_range(1, 63));
      end else begin
        if (r < 20 + flip_pct) cur = cur ^ CH'($urandom_range(1, 63));
        lv = cur;
      end
      send_tick(lv);
      if (pause_mid && k == n / 2) wait_drained();
    end
  endtask

  initial begin
    logic [CH-1:0] burst[$];
    logic [CH-1:0] slow_lv;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers come out of reset at their defaults
    check_reg(REG_ACTIVE_LEVELS);
    check_reg(REG_DEBOUNCE_TICKS);

    // Active high, zero debounce: full presses, aborted release, mixed edges
    program_reg(REG_ACTIVE_LEVELS, 8'h3F);
    program_reg(REG_DEBOUNCE_TICKS, 8'd0);
    burst = '{6'h00, 6'h3F, 6'h3F, 6'h3F, 6'h00, 6'h3F, 6'h00, 6'h00,
              6'h15, 6'h15, 6'h2A, 6'h2A, 6'h2A, 6'h01, 6'h00, 6'h00};
    foreach (burst[k]) send_tick(burst[k]);
    quiesce();

    // Active low, one tick of debounce: presses on all channels, then a lone release on one
    program_reg(REG_ACTIVE_LEVELS, 8'h00);
    program_reg(REG_DEBOUNCE_TICKS, 8'd1);
    burst = '{6'h00, 6'h00, 6'h00, 6'h20, 6'h20, 6'h20};
    foreach (burst[k]) send_tick(burst[k]);
    quiesce();

    // Mixed polarity, sender idles lightly and receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 52;
    program_reg(REG_ACTIVE_LEVELS, 8'($urandom_range(1, 62)));
    program_reg(REG_DEBOUNCE_TICKS, 8'd2);
    run_random(RAND_TICKS, 15, 1'b0);
    quiesce();

    // Swap the idling, pause the sender half way until all edges are out
    send_idle_pct = 52;
    recv_idle_pct = 25;
    program_reg(REG_ACTIVE_LEVELS, 8'h00);
    program_reg(REG_DEBOUNCE_TICKS, 8'd3);
    run_random(RAND_TICKS, 15, 1'b1);
    quiesce();

    // No idling; hold the receiver off so the block fills and stalls its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_reg(REG_ACTIVE_LEVELS, 8'h3F);
    program_reg(REG_DEBOUNCE_TICKS, 8'd0);
    hold_left = LONG_HOLD;
    run_random(RAND_TICKS, 25, 1'b0);
    quiesce();

    // Longest debounce: load the full countdown, then flip back before it expires
    program_reg(REG_ACTIVE_LEVELS, 8'($urandom_range(63)));
    program_reg(REG_DEBOUNCE_TICKS, 8'd255);
    slow_lv = CH'($urandom_range(63));
    repeat (ABORT_HOLD) send_tick(slow_lv);
    repeat (ABORT_HOLD) send_tick(~slow_lv);
    quiesce();

    // Longer debounce: hold a level and its inverse long enough to confirm
    program_reg(REG_DEBOUNCE_TICKS, 8'(SLOW_TICKS));
    repeat (SLOW_HOLD) send_tick(slow_lv);
    repeat (SLOW_HOLD) send_tick(~slow_lv);
    quiesce();

    if (board.owed() != 0) board.flag($sformatf("%0d edges never arrived", board.owed()));

    $display("Run covered %0d ticks and %0d edges (%0d presses, %0d releases), %0d mismatches",
             board.ticks_taken, board.presses + board.releases, board.presses,
             board.releases, board.errors);
    $display("Debounce 0 to %0d confirmed, 255 loaded and aborted, both polarities,",
             SLOW_TICKS);
    $display("three idle mixes and a long output stall");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcd_pkg.sv
hw/rtl/mcd_front.sv
hw/rtl/mcd_queue.sv
hw/rtl/mcd_back.sv
hw/rtl/multi_channel_debounce_fsm.sv
tb/tb_multi_channel_debounce_fsm.sv
